// ===== hdl/tccs_pkg.sv =====
package tccs_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Fixed field widths of the item and result channels.
  localparam int ACT_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int CELL_W      = CHAR_W + ATTR_W;

  // Register port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Character and attribute constants.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT       = 2'd0,
    ACT_BACKSPACE = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

endpackage

// ===== hdl/tccs_apb_regs.sv =====
module tccs_apb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tccs_pkg::PADDR_W-1:0]  paddr,
  input  logic [tccs_pkg::PDATA_W-1:0]  pwdata,
  output logic [tccs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [tccs_pkg::ATTR_W-1:0]   color_attr
);
  import tccs_pkg::*;

  logic [ATTR_W-1:0] color_attr_r;
  logic [ATTR_W-1:0] color_attr_nxt;
  logic              attr_sel;

  // The only register sits at byte address 0.
  assign attr_sel = (paddr[PADDR_W-1:2] == '0);

  always_comb begin
    color_attr_nxt = color_attr_r;
    if (psel && penable && pwrite && attr_sel) begin
      color_attr_nxt = pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_attr_r <= RESET_ATTR;
    end else begin
      color_attr_r <= color_attr_nxt;
    end
  end

  assign prdata     = attr_sel ? PDATA_W'(color_attr_r) : '0;
  assign pready     = 1'b1;
  assign color_attr = color_attr_r;

endmodule

// ===== hdl/tccs_screen_ram.sv =====
module tccs_screen_ram #(
  parameter int DEPTH = tccs_pkg::ROWS_DEF * tccs_pkg::COLUMNS_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [tccs_pkg::CELL_W-1:0]  wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [tccs_pkg::CELL_W-1:0]  rdata
);
  import tccs_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tccs_ctrl.sv =====
module tccs_ctrl #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [tccs_pkg::ATTR_W-1:0]       color_attr,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tccs_pkg::ACT_W-1:0]        in_action,
  input  logic [tccs_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [tccs_pkg::ROW_FIELD_W-1:0]  in_read_row,
  input  logic [tccs_pkg::COL_FIELD_W-1:0]  in_read_col,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tccs_pkg::CHAR_W-1:0]       out_cell_char,
  output logic [tccs_pkg::ATTR_W-1:0]       out_cell_attr,
  output logic [tccs_pkg::ROW_FIELD_W-1:0]  out_cur_row,
  output logic [tccs_pkg::COL_FIELD_W-1:0]  out_cur_col,
  output logic                              mem_we,
  output logic [$clog2(ROWS*COLUMNS)-1:0]   mem_waddr,
  output logic [tccs_pkg::CELL_W-1:0]       mem_wdata,
  output logic [$clog2(ROWS*COLUMNS)-1:0]   mem_raddr,
  input  logic [tccs_pkg::CELL_W-1:0]       mem_rdata
);
  import tccs_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int RW1   = RW + 1;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CW1   = CW + 1;

  localparam logic [RW:0]    ROWS_X    = RW1'(ROWS);
  localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW:0]    COLS_X    = CW1'(COLUMNS);
  localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_READ  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        base_r, base_nxt;
  action_t              act_r, act_nxt;
  logic [CHAR_W-1:0]    ch_r, ch_nxt;
  logic [ROW_FIELD_W-1:0] rrow_r, rrow_nxt;
  logic [COL_FIELD_W-1:0] rcol_r, rcol_nxt;
  logic [AW-1:0]        sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]        sweep_last_r, sweep_last_nxt;
  logic [ATTR_W-1:0]    sweep_attr_r, sweep_attr_nxt;
  logic                 sweep_resp_r, sweep_resp_nxt;
  logic [CELL_W-1:0]    cell_r, cell_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]    out_cell_r, out_cell_nxt;
  logic [RW-1:0]        out_row_r, out_row_nxt;
  logic [CW-1:0]        out_col_r, out_col_nxt;

  logic [RW:0]          row_inc;
  logic [CW:0]          col_inc;
  logic [RW-1:0]        base_inc;
  logic [AW-1:0]        top_addr;
  logic                 read_ok;

  // Logical row plus the scroll offset, wrapped, times the row length, plus the column.
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col,
                                              input logic [RW-1:0] base);
    logic [RW:0]   sum;
    logic [RW-1:0] prow;
    sum  = {1'b0, row} + {1'b0, base};
    prow = (sum >= ROWS_X) ? RW'(sum - ROWS_X) : RW'(sum);
    return AW'(prow) * COLS_A + AW'(col);
  endfunction

  assign row_inc  = {1'b0, row_r} + RW1'(1);
  assign col_inc  = {1'b0, col_r} + CW1'(1);
  assign base_inc = (base_r == LAST_ROW) ? '0 : RW'(base_r + RW'(1));
  assign top_addr = AW'(base_r) * COLS_A;
  assign read_ok  = (int'(rrow_r) < ROWS) && (int'(rcol_r) < COLUMNS);

  assign mem_raddr = cell_addr(RW'(rrow_r), CW'(rcol_r), base_r);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    base_nxt       = base_r;
    act_nxt        = act_r;
    ch_nxt         = ch_r;
    rrow_nxt       = rrow_r;
    rcol_nxt       = rcol_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_last_nxt = sweep_last_r;
    sweep_attr_nxt = sweep_attr_r;
    sweep_resp_nxt = sweep_resp_r;
    cell_nxt       = cell_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_cell_nxt   = out_cell_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    mem_we         = 1'b0;
    mem_waddr      = cell_addr(row_r, col_r, base_r);
    mem_wdata      = {color_attr, ch_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = action_t'(in_action);
          ch_nxt    = in_char_code;
          rrow_nxt  = in_read_row;
          rcol_nxt  = in_read_col;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        cell_nxt  = '0;
        state_nxt = S_DONE;
        case (act_r)
          ACT_PUT: begin
            if (ch_r != NEWLINE_CODE) begin
              mem_we = 1'b1;
            end
            if (ch_r == NEWLINE_CODE || col_inc == COLS_X) begin
              col_nxt = '0;
              if (row_inc == ROWS_X) begin
                // Scroll: the old top row becomes the new bottom row.
                row_nxt        = LAST_ROW;
                base_nxt       = base_inc;
                sweep_addr_nxt = top_addr;
                sweep_last_nxt = top_addr + COLS_A - AW'(1);
                sweep_attr_nxt = color_attr;
                sweep_resp_nxt = 1'b1;
                state_nxt      = S_SWEEP;
              end else begin
                row_nxt = RW'(row_inc);
              end
            end else begin
              col_nxt = CW'(col_inc);
            end
          end
          ACT_BACKSPACE: begin
            if (col_r != '0) begin
              col_nxt   = col_r - CW'(1);
              mem_we    = 1'b1;
              mem_waddr = cell_addr(row_r, col_r - CW'(1), base_r);
              mem_wdata = {color_attr, SPACE_CODE};
            end
          end
          ACT_CLEAR: begin
            row_nxt        = '0;
            col_nxt        = '0;
            base_nxt       = '0;
            sweep_addr_nxt = '0;
            sweep_last_nxt = LAST_CELL;
            sweep_attr_nxt = color_attr;
            sweep_resp_nxt = 1'b1;
            state_nxt      = S_SWEEP;
          end
          default: begin
            if (read_ok) begin
              state_nxt = S_READ;
            end
          end
        endcase
      end

      S_READ: begin
        cell_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_r;
        mem_wdata = {sweep_attr_r, SPACE_CODE};
        if (sweep_addr_r == sweep_last_r) begin
          state_nxt = sweep_resp_r ? S_DONE : S_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + AW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = cell_r;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
      sweep_addr_r <= '0;
      sweep_last_r <= LAST_CELL;
      sweep_attr_r <= RESET_ATTR;
      sweep_resp_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      base_r       <= base_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_last_r <= sweep_last_nxt;
      sweep_attr_r <= sweep_attr_nxt;
      sweep_resp_r <= sweep_resp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    ch_r       <= ch_nxt;
    rrow_r     <= rrow_nxt;
    rcol_r     <= rcol_nxt;
    cell_r     <= cell_nxt;
    out_cell_r <= out_cell_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_cell_char = out_cell_r[CHAR_W-1:0];
  assign out_cell_attr = out_cell_r[CELL_W-1:CHAR_W];
  assign out_cur_row   = ROW_FIELD_W'(out_row_r);
  assign out_cur_col   = COL_FIELD_W'(out_col_r);

endmodule

// ===== hdl/text_console_cursor_scroll_top.sv =====
// Text console engine: a screen of ROWS x COLUMNS character cells, each a
// character byte below an attribute byte, plus a cursor. A put item writes
// the character with the programmed attribute and advances the cursor, a
// newline moves to the start of the next row, backspace blanks the cell left
// of the cursor, clear blanks the screen and homes the cursor, and a read
// item returns one cell. Every item gives exactly one result carrying the
// cursor after the item. The cells live in one single-port-write RAM with a
// registered read, and scrolling rotates a top-row offset instead of moving
// data, so a scroll only blanks one row. The block handles one item at a
// time: a read waits on the registered RAM read, a put that scrolls first
// blanks one row, and clear blanks every cell, before the result is given
// and the next item is accepted. After reset the screen is blanked by a
// sweep over all ROWS*COLUMNS cells (2000 at the default 80x25) during
// which no item is accepted; register writes are taken at any time. The
// attribute register sits at byte address 0 and reset sets it to 0x0F.
module text_console_cursor_scroll_top #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tccs_pkg::PADDR_W-1:0]      paddr,
  input  logic [tccs_pkg::PDATA_W-1:0]      pwdata,
  output logic [tccs_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tccs_pkg::ACT_W-1:0]        in_action,
  input  logic [tccs_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [tccs_pkg::ROW_FIELD_W-1:0]  in_read_row,
  input  logic [tccs_pkg::COL_FIELD_W-1:0]  in_read_col,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tccs_pkg::CHAR_W-1:0]       out_cell_char,
  output logic [tccs_pkg::ATTR_W-1:0]       out_cell_attr,
  output logic [tccs_pkg::ROW_FIELD_W-1:0]  out_cur_row,
  output logic [tccs_pkg::COL_FIELD_W-1:0]  out_cur_col
);
  import tccs_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [ATTR_W-1:0] color_attr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // Attribute register behind the register port.
  tccs_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .color_attr (color_attr)
  );

  // Screen cells, stored in physical row order.
  tccs_screen_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Cursor, scroll offset, item sequencer and result register.
  tccs_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .color_attr    (color_attr),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .out_cur_row   (out_cur_row),
    .out_cur_col   (out_cur_col),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

endmodule

// ===== hdl/tccs_checker.sv =====
module tccs_checker #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tccs_pkg::CHAR_W-1:0]       out_cell_char,
  input logic [tccs_pkg::ATTR_W-1:0]       out_cell_attr,
  input logic [tccs_pkg::ROW_FIELD_W-1:0]  out_cur_row,
  input logic [tccs_pkg::COL_FIELD_W-1:0]  out_cur_col
);
  import tccs_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_char) &&
      $stable(out_cell_attr) && $stable(out_cur_row) && $stable(out_cur_col))
    else $error("result changed while stalled");

  // Items are handled one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // The cursor row never leaves the screen.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_cur_row) < ROWS)
    else $error("cursor row off screen");

  // The cursor column never leaves the screen.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_cur_col) < COLUMNS)
    else $error("cursor column off screen");

endmodule

bind text_console_cursor_scroll_top tccs_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_cell_char (out_cell_char),
  .out_cell_attr (out_cell_attr),
  .out_cur_row   (out_cur_row),
  .out_cur_col   (out_cur_col)
);

// ===== test/tb_text_console_cursor_scroll_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the text console engine. Every accepted item is run
// through a predictor that keeps its own copy of the screen, the cursor and
// the attribute register. Each accepted result is compared with the oldest
// queued report, taken from the table where it gives one, else from the predictor.
module tb_text_console_cursor_scroll_top;
  import tccs_pkg::*;

  localparam int ROWS = ROWS_DEF;
  localparam int COLS = COLUMNS_DEF;

  // The attribute register is the only register, at byte address 0.
  localparam logic [PADDR_W-1:0] ADDR_COLOR_ATTR = '0;

  localparam int NDIR      = 23;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 250;
  localparam int SHOWN_MAX = 10;
  localparam int IDLE_PCT  = 32;

  // One result as it leaves the block: the cell that was read (zero for
  // anything but a read) and the cursor after the item.
  typedef struct packed {
    logic [CHAR_W-1:0]      ch;
    logic [ATTR_W-1:0]      attr;
    logic [ROW_FIELD_W-1:0] row;
    logic [COL_FIELD_W-1:0] col;
  } console_report_t;

  // One line of the directed table. A line is sent reps times in a row. Where
  // typed is set, the report is given here; otherwise the predictor gives it.
  typedef struct packed {
    action_t                act;
    logic [CHAR_W-1:0]      ch;
    logic [ROW_FIELD_W-1:0] rr;
    logic [COL_FIELD_W-1:0] rc;
    logic [7:0]             reps;
    logic                   typed;
    console_report_t        want;
  } directed_row_t;

  // The directed part runs with the attribute left at its reset value.
  localparam directed_row_t DIRECTED [NDIR] = '{
    // A fresh screen is all spaces with the reset attribute, corners included.
    '{ACT_READ,      8'h00, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h20, 8'h0F, 5'd0, 7'd0}},
    '{ACT_READ,      8'h00, 5'd24, 7'd79,  8'd1,  1'b1, '{8'h20, 8'h0F, 5'd0, 7'd0}},
    // Reads outside the screen return an empty cell.
    '{ACT_READ,      8'h00, 5'd25, 7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{ACT_READ,      8'h00, 5'd0,  7'd80,  8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{ACT_READ,      8'h00, 5'd31, 7'd127, 8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    // Backspace at the left edge leaves everything alone.
    '{ACT_BACKSPACE, 8'h00, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    // Character extremes go into the screen as plain bytes.
    '{ACT_PUT,       8'h41, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
    '{ACT_PUT,       8'h00, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
    '{ACT_PUT,       8'hFF, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd3}},
    '{ACT_READ,      8'h00, 5'd0,  7'd2,   8'd1,  1'b1, '{8'hFF, 8'h0F, 5'd0, 7'd3}},
    '{ACT_BACKSPACE, 8'h00, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
    '{ACT_READ,      8'h00, 5'd0,  7'd2,   8'd1,  1'b1, '{8'h20, 8'h0F, 5'd0, 7'd2}},
    '{ACT_READ,      8'h00, 5'd0,  7'd1,   8'd1,  1'b1, '{8'h00, 8'h0F, 5'd0, 7'd2}},
    // Newline writes nothing and moves to the start of the next row.
    '{ACT_PUT,       8'h0A, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
    // A full row of characters wraps the cursor at the row end.
    '{ACT_PUT,       8'h7E, 5'd0,  7'd0,   8'd80, 1'b0, '0},
    '{ACT_READ,      8'h00, 5'd1,  7'd79,  8'd1,  1'b0, '0},
    // Enough newlines to run past the last row and scroll once.
    '{ACT_PUT,       8'h0A, 5'd0,  7'd0,   8'd23, 1'b0, '0},
    '{ACT_READ,      8'h00, 5'd24, 7'd0,   8'd1,  1'b0, '0},
    // Filling the bottom row scrolls through the wrap.
    '{ACT_PUT,       8'h55, 5'd0,  7'd0,   8'd85, 1'b0, '0},
    '{ACT_READ,      8'h00, 5'd23, 7'd79,  8'd1,  1'b0, '0},
    '{ACT_BACKSPACE, 8'h00, 5'd0,  7'd0,   8'd1,  1'b0, '0},
    // Clear homes the cursor and blanks every cell.
    '{ACT_CLEAR,     8'h00, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{ACT_READ,      8'h00, 5'd24, 7'd79,  8'd1,  1'b1, '{8'h20, 8'h0F, 5'd0, 7'd0}}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ACT_W-1:0]       in_action = '0;
  logic [CHAR_W-1:0]      in_char_code = '0;
  logic [ROW_FIELD_W-1:0] in_read_row = '0;
  logic [COL_FIELD_W-1:0] in_read_col = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CHAR_W-1:0]      out_cell_char;
  logic [ATTR_W-1:0]      out_cell_attr;
  logic [ROW_FIELD_W-1:0] out_cur_row;
  logic [COL_FIELD_W-1:0] out_cur_col;

  // Predictor state: the screen with the attribute in the high byte of each
  // cell, the cursor, and the attribute that the register holds.
  logic [CELL_W-1:0] screen_copy [ROWS][COLS];
  int                pred_row;
  int                pred_col;
  logic [ATTR_W-1:0] shade;

  console_report_t awaited[$];
  int              mismatches = 0;

  // While calm is set, neither side of the bench idles.
  bit calm = 1'b0;

  text_console_cursor_scroll_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .out_cur_row   (out_cur_row),
    .out_cur_col   (out_cur_col)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous bound on the whole run, far above the slowest correct run
  // including the blanking sweep after reset and every clear.
  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Fills every cell with a space in the given attribute and homes the cursor.
  function automatic void blank_screen(input logic [ATTR_W-1:0] attr);
    int r;
    int c;
    for (r = 0; r < ROWS; r++) begin
      for (c = 0; c < COLS; c++) begin
        screen_copy[r][c] = {attr, SPACE_CODE};
      end
    end
    pred_row = 0;
    pred_col = 0;
  endfunction

  // Applies one item to the predictor and returns the report it must give.
  function automatic console_report_t console_apply(input action_t act,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [ROW_FIELD_W-1:0] rr,
                                                    input logic [COL_FIELD_W-1:0] rc);
    console_report_t rep;
    int r;
    int c;
    rep = '0;
    case (act)
      ACT_PUT: begin
        if (ch == NEWLINE_CODE) begin
          pred_col = 0;
          pred_row++;
        end else begin
          screen_copy[pred_row][pred_col] = {shade, ch};
          pred_col++;
          if (pred_col >= COLS) begin
            pred_col = 0;
            pred_row++;
          end
        end
        // Running off the bottom moves every row up by one and blanks the
        // bottom row with the current attribute.
        if (pred_row >= ROWS) begin
          for (r = 0; r < ROWS - 1; r++) begin
            for (c = 0; c < COLS; c++) begin
              screen_copy[r][c] = screen_copy[r+1][c];
            end
          end
          for (c = 0; c < COLS; c++) begin
            screen_copy[ROWS-1][c] = {shade, SPACE_CODE};
          end
          pred_row = ROWS - 1;
        end
      end
      ACT_BACKSPACE: begin
        if (pred_col != 0) begin
          pred_col--;
          screen_copy[pred_row][pred_col] = {shade, SPACE_CODE};
        end
      end
      ACT_CLEAR: begin
        blank_screen(shade);
      end
      default: begin
        if (rr < ROWS && rc < COLS) begin
          {rep.attr, rep.ch} = screen_copy[rr][rc];
        end
      end
    endcase
    rep.row = ROW_FIELD_W'(pred_row);
    rep.col = COL_FIELD_W'(pred_col);
    return rep;
  endfunction

  // Register write: setup cycle, then access cycle until pready. Called at a
  // rising edge; returns at the edge where the write takes place.
  task automatic write_color_attr(input logic [ATTR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_COLOR_ATTR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shade = value;
  endtask

  // Presents one item and waits until it is accepted. Called at a rising edge
  // and returns at the accepting edge, so back-to-back items keep in_valid
  // high with a single assignment per edge. A random gap of idle cycles may
  // come first, unless the bench is in its calm stretch.
  task automatic send_item(input action_t act, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_FIELD_W-1:0] rr,
                           input logic [COL_FIELD_W-1:0] rc,
                           input logic typed, input console_report_t want);
    console_report_t predicted;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_char_code <= ch;
    in_read_row  <= rr;
    in_read_col  <= rc;
    do @(posedge clk); while (!in_ready);
    // The predictor always advances; a typed report takes its place in the
    // queue where the table gives one.
    predicted = console_apply(act, ch, rr, rc);
    awaited.push_back(typed ? want : predicted);
  endtask

  // The result side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every accepted result is matched against the oldest queued report.
  always @(posedge clk) begin : report_check
    console_report_t seen;
    console_report_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_cell_char, out_cell_attr, out_cur_row, out_cur_col};
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX) begin
          $display("%0t: result with none awaited: char %02h attr %02h cursor %0d,%0d",
                   $realtime, seen.ch, seen.attr, seen.row, seen.col);
        end
      end else begin
        want = awaited.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX) begin
            $display("%0t: expected char %02h attr %02h cursor %0d,%0d", $realtime,
                     want.ch, want.attr, want.row, want.col);
            $display("%0t:   actual char %02h attr %02h cursor %0d,%0d", $realtime,
                     seen.ch, seen.attr, seen.row, seen.col);
          end
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t          d;
    action_t                act;
    logic [CHAR_W-1:0]      ch;
    logic [ROW_FIELD_W-1:0] rr;
    logic [COL_FIELD_W-1:0] rc;
    logic [ATTR_W-1:0]      phase_shade [PHASES];
    int                     i;
    int                     p;
    int                     n;
    int                     pick;

    // Attribute for each random phase: both extremes, a lone top bit, a lone
    // low bit and two random values.
    phase_shade[0] = 8'hFF;
    phase_shade[1] = 8'h00;
    phase_shade[2] = ATTR_W'($urandom_range(255));
    phase_shade[3] = 8'h80;
    phase_shade[4] = ATTR_W'($urandom_range(255));
    phase_shade[5] = 8'h01;

    shade = RESET_ATTR;
    blank_screen(RESET_ATTR);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The block blanks its screen after reset before it takes any item; the
    // first send simply waits on in_ready through that sweep.
    for (i = 0; i < NDIR; i++) begin
      d = DIRECTED[i];
      repeat (d.reps) send_item(d.act, d.ch, d.rr, d.rc, d.typed, d.want);
    end
    in_valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      // The register is only written once every report is back.
      while (awaited.size() != 0) @(posedge clk);
      write_color_attr(phase_shade[p]);
      // The third phase runs with no idling on either side.
      calm = (p == 2);
      for (n = 0; n < PHASE_LEN; n++) begin
        // Clears are kept rare so the cursor gets to the bottom and scrolls;
        // a quarter of the puts are newlines for the same reason.
        pick = $urandom_range(999);
        if (pick < 3) begin
          act = ACT_CLEAR;
        end else if (pick < 550) begin
          act = ACT_PUT;
        end else if (pick < 700) begin
          act = ACT_BACKSPACE;
        end else begin
          act = ACT_READ;
        end
        ch = CHAR_W'($urandom_range(255));
        if (act == ACT_PUT && $urandom_range(3) == 0) begin
          ch = NEWLINE_CODE;
        end
        // Most reads hit the screen, half of them on the cursor row where the
        // latest writes are; the rest use the whole width of the fields.
        if (act == ACT_READ && $urandom_range(99) >= 15) begin
          rr = ($urandom_range(1) == 0) ? ROW_FIELD_W'(pred_row)
                                        : ROW_FIELD_W'($urandom_range(ROWS - 1));
          rc = COL_FIELD_W'($urandom_range(COLS - 1));
        end else begin
          rr = ROW_FIELD_W'($urandom_range(31));
          rc = COL_FIELD_W'($urandom_range(127));
        end
        send_item(act, ch, rr, rc, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end
    calm = 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    // A short drain catches any stray result after the last expected one.
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tccs_pkg.sv
hdl/tccs_apb_regs.sv
hdl/tccs_screen_ram.sv
hdl/tccs_ctrl.sv
hdl/text_console_cursor_scroll_top.sv
hdl/tccs_checker.sv
test/tb_text_console_cursor_scroll_top.sv
